### rtl/per_thread_bump_allocator_macros.svh
// Assertion macros used by the bump allocator controller.
// Each macro expands to one labeled concurrent assertion on clk, disabled while rst_n is low.
`ifndef PER_THREAD_BUMP_ALLOCATOR_MACROS_SVH
`define PER_THREAD_BUMP_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bpa_pkg.sv
// Shared types and constants for the per-thread bump allocator.
// No dependencies; every other RTL file but the macros header refers to it by scoped names.
package bpa_pkg;

  // Operation codes carried in the request kind field.
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_MARKER = 2'd1;
  localparam logic [1:0] KIND_REWIND = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_POOL_BASE   = 1'b0;
  localparam logic CFG_REGION_SIZE = 1'b1;

  // Field widths.
  localparam int ADDR_W   = 32;
  localparam int REGION_W = 29;
  localparam int TID_W    = 3;
  localparam int SHIFT_W  = 4;
  // Exact width for base, pointer, alignment and end arithmetic.
  localparam int WIDE_W   = 36;
  // Largest number of threads that the thread index can reach.
  localparam int MAX_TID  = 8;

  localparam logic [REGION_W-1:0] REGION_SIZE_RST = 29'd4096;

  typedef struct packed {
    logic [1:0]          kind;
    logic [TID_W-1:0]    thread_index;
    logic [ADDR_W-1:0]   request_size;
    logic [SHIFT_W-1:0]  align_shift;
    logic [ADDR_W-1:0]   target_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [ADDR_W-1:0] granted_size;
    logic [1:0]        status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic calc_prod;
    logic calc_sum;
    logic commit;
  } ctrl_cmd_t;

endpackage

### rtl/bpa_req_if.sv
// Request channel of the bump allocator: valid/ready handshake plus request fields.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [bpa_pkg::TID_W-1:0]      thread_index;
  logic [bpa_pkg::ADDR_W-1:0]     request_size;
  logic [bpa_pkg::SHIFT_W-1:0]    align_shift;
  logic [bpa_pkg::ADDR_W-1:0]     target_addr;

  modport source (output valid, kind, thread_index, request_size, align_shift, target_addr,
                  input ready);
  modport sink (input valid, kind, thread_index, request_size, align_shift, target_addr,
                output ready);
endinterface

### rtl/bpa_rsp_if.sv
// Result channel of the bump allocator: valid/ready handshake plus result fields.
// Depends on bpa_pkg for field widths.
interface bpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bpa_pkg::ADDR_W-1:0] result_addr;
  logic [bpa_pkg::ADDR_W-1:0] granted_size;
  logic [1:0]                 status;

  modport source (output valid, result_addr, granted_size, status, input ready);
  modport sink (input valid, result_addr, granted_size, status, output ready);
endinterface

### rtl/bpa_ctrl.sv
// Controller of the bump allocator: sequences one request through its steps
// and owns both handshakes. Depends on bpa_pkg and the macros header.
`include "per_thread_bump_allocator_macros.svh"

module bpa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpa_pkg::ctrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_EVAL = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  // The result register can take a new beat if it is empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.calc_prod = 1'b1;
        state_nxt     = ST_SUM;
      end
      ST_SUM: begin
        cmd.calc_sum = 1'b1;
        state_nxt    = ST_EVAL;
      end
      ST_EVAL: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag: set by a commit, cleared when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BPA_ASSERT_NEXT(a_accept_starts_mul, in_fire, state_r == ST_MUL, "accept did not start a request")
  `BPA_ASSERT_SAME(a_commit_slot_free, cmd.commit, !out_valid_r || out_ready, "commit overwrote a pending beat")
  `BPA_ASSERT_SAME(a_valid_from_commit, $rose(out_valid_r), $past(cmd.commit), "result valid without a commit")
  `BPA_ASSERT_NEXT(a_stall_holds_eval, state_r == ST_EVAL && !slot_free, state_r == ST_EVAL, "left evaluation while stalled")

endmodule

### rtl/bpa_datapath.sv
// Datapath of the bump allocator: configuration registers, per-thread fill offsets,
// region arithmetic and the result register. Depends on bpa_pkg.
module bpa_datapath #(
  parameter int THREADS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
  input  bpa_pkg::req_t                 req,
  input  bpa_pkg::ctrl_cmd_t            cmd,
  output bpa_pkg::rsp_t                 rsp
);

  // Only threads the index field can name get storage.
  localparam int EFF   = (THREADS < bpa_pkg::MAX_TID) ? THREADS : bpa_pkg::MAX_TID;
  localparam int IDX_W = (EFF > 1) ? $clog2(EFF) : 1;
  localparam int W     = bpa_pkg::WIDE_W;
  localparam int RW    = bpa_pkg::REGION_W;

  // Configuration registers.
  logic [bpa_pkg::ADDR_W-1:0] pool_base_r;
  logic [RW-1:0]              region_size_r;

  // Fill offsets, one per thread.
  logic [RW-1:0] fill_r [EFF];

  // Captured request.
  bpa_pkg::req_t req_r;
  logic [IDX_W-1:0] idx;

  // First step: region offset product and the thread's fill.
  logic [bpa_pkg::ADDR_W-1:0] prod_r;
  logic [RW-1:0]              fill_sel_r;
  logic                       tid_ok_r;

  // Second step: region base, current pointer and region end.
  logic [W-1:0] base_r, cur_r, limit_r;

  // Evaluation.
  logic [W-1:0] align_m1, aligned, end_addr;
  logic         fits, rewind_ok;
  bpa_pkg::rsp_t rsp_nxt;
  logic          wr_en;
  logic [RW-1:0] wr_val;

  assign idx = req_r.thread_index[IDX_W-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      region_size_r <= bpa_pkg::REGION_SIZE_RST;
    end else if (cfg_we) begin
      if (cfg_index == bpa_pkg::CFG_POOL_BASE) begin
        pool_base_r <= cfg_wdata;
      end else begin
        region_size_r <= cfg_wdata[RW-1:0];
      end
    end
  end

  // Request capture and the two address steps.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req;
    end
    if (cmd.calc_prod) begin
      prod_r     <= bpa_pkg::ADDR_W'(req_r.thread_index) * bpa_pkg::ADDR_W'(region_size_r);
      tid_ok_r   <= (32'(req_r.thread_index) < 32'(EFF));
      fill_sel_r <= fill_r[idx];
    end
    if (cmd.calc_sum) begin
      base_r  <= W'(pool_base_r) + W'(prod_r);
      cur_r   <= W'(pool_base_r) + W'(prod_r) + W'(fill_sel_r);
      limit_r <= W'(pool_base_r) + W'(prod_r) + W'(region_size_r);
    end
  end

  // Alignment, fit check and rewind range check.
  always_comb begin
    align_m1  = (W'(1) << req_r.align_shift) - W'(1);
    aligned   = (cur_r + align_m1) & ~align_m1;
    end_addr  = aligned + W'(req_r.request_size);
    fits      = (end_addr <= limit_r);
    rewind_ok = (W'(req_r.target_addr) >= base_r) && (W'(req_r.target_addr) <= cur_r);
  end

  // Result selection and fill update.
  always_comb begin
    rsp_nxt = '0;
    wr_en   = 1'b0;
    wr_val  = RW'(end_addr - base_r);
    case (req_r.kind)
      bpa_pkg::KIND_ALLOC: begin
        if (tid_ok_r && fits) begin
          rsp_nxt.result_addr  = aligned[bpa_pkg::ADDR_W-1:0];
          rsp_nxt.granted_size = req_r.request_size;
          wr_en                = 1'b1;
        end else begin
          rsp_nxt.status = bpa_pkg::STATUS_NO_SPACE;
        end
      end
      bpa_pkg::KIND_MARKER: begin
        if (tid_ok_r) begin
          rsp_nxt.result_addr = cur_r[bpa_pkg::ADDR_W-1:0];
        end
      end
      bpa_pkg::KIND_REWIND: begin
        wr_val = RW'(W'(req_r.target_addr) - base_r);
        if (tid_ok_r && rewind_ok) begin
          rsp_nxt.result_addr = req_r.target_addr;
          wr_en               = 1'b1;
        end else begin
          rsp_nxt.status = bpa_pkg::STATUS_BAD_RANGE;
        end
      end
      default: begin
        rsp_nxt = '0;
      end
    endcase
  end

  // Fill offsets clear at reset and change only on a successful commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < EFF; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cmd.commit && wr_en) begin
      fill_r[idx] <= wr_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_nxt;
    end
  end

endmodule

### rtl/per_thread_bump_allocator.sv
// Per-thread bump allocator, one result beat per request beat.
// A request is accepted, then stepped through the region product, the sums and evaluation.
// The controller takes one request at a time through the shared multiply and add stages and
// accepts no new one until it commits; a result waiting on out_rsp.ready holds evaluation.
// Reset (rst_n low, synchronous): fill offsets clear, pool_base 0, region_size 4096, no beats.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl and bpa_datapath.
module per_thread_bump_allocator #(
  parameter int THREADS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bpa_req_if.sink                     in_req,
  bpa_rsp_if.source                   out_rsp,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]  cfg_wdata
);

  bpa_pkg::ctrl_cmd_t cmd;
  bpa_pkg::req_t      req;
  bpa_pkg::rsp_t      rsp;
  logic               in_ready;
  logic               out_valid;

  // Gather the request fields.
  always_comb begin
    req.kind         = in_req.kind;
    req.thread_index = in_req.thread_index;
    req.request_size = in_req.request_size;
    req.align_shift  = in_req.align_shift;
    req.target_addr  = in_req.target_addr;
  end

  assign in_req.ready         = in_ready;
  assign out_rsp.valid        = out_valid;
  assign out_rsp.result_addr  = rsp.result_addr;
  assign out_rsp.granted_size = rsp.granted_size;
  assign out_rsp.status       = rsp.status;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .THREADS (THREADS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

### bench/tb_top.sv
// Self-checking bench for per_thread_bump_allocator: directed corner requests, then random traffic.
// Expected results come from a shadow allocator kept inside the bench.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  import bpa_pkg::*;

  localparam int THREADS = 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 140;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;

  bpa_req_if req_bus ();
  bpa_rsp_if rsp_bus ();

  // Shadow copy of the allocator state and its configuration registers.
  logic [ADDR_W-1:0] shadow_pool_base;
  logic [REGION_W-1:0] shadow_region_size;
  logic [REGION_W-1:0] shadow_fill [THREADS];

  rsp_t pending_outcomes [$];
  int mismatch_count;
  int unsigned idle_max;

  per_thread_bump_allocator #(
    .THREADS(THREADS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_bus),
    .out_rsp(rsp_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the result of one request and advances the shadow state.
  // All address math is done at 64 bits so that no compare wraps.
  function automatic rsp_t allocator_outcome(input req_t r);
    rsp_t o;
    logic [63:0] base;
    logic [63:0] cur;
    logic [63:0] align;
    logic [63:0] aligned;
    logic [63:0] stop;
    logic [63:0] target;
    o = '0;
    if (r.kind == KIND_UNUSED) return o;
    if (r.thread_index >= THREADS) begin
      if (r.kind == KIND_ALLOC) o.status = STATUS_NO_SPACE;
      else if (r.kind == KIND_REWIND) o.status = STATUS_BAD_RANGE;
      return o;
    end
    base = 64'(shadow_pool_base) + 64'(r.thread_index) * 64'(shadow_region_size);
    cur = base + 64'(shadow_fill[r.thread_index]);
    target = 64'(r.target_addr);
    case (r.kind)
      KIND_ALLOC: begin
        align = 64'd1 << r.align_shift;
        aligned = (cur + align - 64'd1) & ~(align - 64'd1);
        stop = aligned + 64'(r.request_size);
        if (stop > base + 64'(shadow_region_size)) begin
          o.status = STATUS_NO_SPACE;
        end else begin
          shadow_fill[r.thread_index] = REGION_W'(stop - base);
          o.result_addr = aligned[ADDR_W-1:0];
          o.granted_size = r.request_size;
          o.status = STATUS_OK;
        end
      end
      KIND_MARKER: begin
        o.result_addr = cur[ADDR_W-1:0];
        o.status = STATUS_OK;
      end
      default: begin
        if (target < base || target > cur) begin
          o.status = STATUS_BAD_RANGE;
        end else begin
          shadow_fill[r.thread_index] = REGION_W'(target - base);
          o.result_addr = r.target_addr;
          o.status = STATUS_OK;
        end
      end
    endcase
    return o;
  endfunction

  function automatic req_t make_request(input logic [1:0] op, input int unsigned tid,
                                        input logic [ADDR_W-1:0] size, input int unsigned shift,
                                        input logic [ADDR_W-1:0] target);
    req_t r;
    r.kind = op;
    r.thread_index = TID_W'(tid);
    r.request_size = size;
    r.align_shift = SHIFT_W'(shift);
    r.target_addr = target;
    return r;
  endfunction

  // Random request, mostly well formed: sizes scaled to the region and rewind
  // targets inside the live part of the region, with some noise mixed in.
  function automatic req_t random_request();
    req_t r;
    logic [63:0] base;
    logic [63:0] cur;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) r.kind = KIND_ALLOC;
    else if (pick < 65) r.kind = KIND_MARKER;
    else if (pick < 95) r.kind = KIND_REWIND;
    else r.kind = KIND_UNUSED;
    r.thread_index = TID_W'($urandom_range(0, THREADS - 1));
    if ($urandom_range(0, 3) == 0) r.align_shift = SHIFT_W'($urandom_range(0, 15));
    else r.align_shift = SHIFT_W'($urandom_range(0, 6));
    pick = $urandom_range(0, 19);
    if (pick == 0) r.request_size = '0;
    else if (pick < 3) r.request_size = $urandom();
    else r.request_size = $urandom_range(0, 32'(shadow_region_size) / 4 + 2);
    base = 64'(shadow_pool_base) + 64'(r.thread_index) * 64'(shadow_region_size);
    cur = base + 64'(shadow_fill[r.thread_index]);
    pick = $urandom_range(0, 19);
    if (pick < 14) r.target_addr = ADDR_W'(base + 64'($urandom_range(0,
                                     32'(shadow_fill[r.thread_index]))));
    else if (pick < 16) r.target_addr = ADDR_W'(cur + 64'd1);
    else if (pick == 16) r.target_addr = ADDR_W'(base - 64'd1);
    else r.target_addr = $urandom();
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one request beat after a random gap and records its expected result.
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = $urandom_range(0, idle_max);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.kind <= r.kind;
    req_bus.thread_index <= r.thread_index;
    req_bus.request_size <= r.request_size;
    req_bus.align_shift <= r.align_shift;
    req_bus.target_addr <= r.target_addr;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_outcomes.push_back(allocator_outcome(r));
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic settle_block();
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [ADDR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_POOL_BASE) shadow_pool_base = value;
    else shadow_region_size = value[REGION_W-1:0];
  endtask

  // Compares one accepted result beat with the oldest expectation.
  task automatic check_outcome();
    rsp_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch("result beat with no request outstanding");
      return;
    end
    want = pending_outcomes.pop_front();
    if (rsp_bus.result_addr !== want.result_addr)
      report_mismatch($sformatf("result_addr %h, expected %h",
                                rsp_bus.result_addr, want.result_addr));
    if (rsp_bus.granted_size !== want.granted_size)
      report_mismatch($sformatf("granted_size %h, expected %h",
                                rsp_bus.granted_size, want.granted_size));
    if (rsp_bus.status !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", rsp_bus.status, want.status));
  endtask

  // Result side: random stall before each beat, then check it.
  initial begin : result_sink
    int unsigned stall;
    rsp_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, idle_max);
      if (stall != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
      check_outcome();
    end
  end

  // Ends the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Markers straight after reset show the default base and region size.
  task automatic test_reset_markers();
    send_request(make_request(KIND_MARKER, 0, '0, 0, '0));
    send_request(make_request(KIND_MARKER, THREADS - 1, '0, 0, '0));
  endtask

  // Zero size, alignment padding, exact fill and overflow of a region.
  task automatic test_allocate_edges();
    send_request(make_request(KIND_ALLOC, 0, 32'd0, 0, '0));
    send_request(make_request(KIND_ALLOC, 0, 32'd1, 0, '0));
    send_request(make_request(KIND_ALLOC, 0, 32'd100, 4, '0));
    send_request(make_request(KIND_ALLOC, 0, 32'd16, 15, '0));
    send_request(make_request(KIND_ALLOC, 1, 32'hFFFF_FFFF, 0, '0));
    send_request(make_request(KIND_ALLOC, 2, 32'd4096, 0, '0));
    send_request(make_request(KIND_ALLOC, 2, 32'd0, 0, '0));
    send_request(make_request(KIND_ALLOC, 2, 32'd1, 0, '0));
  endtask

  // Rewinds inside the live range, to the base, above the pointer and below the base.
  task automatic test_rewind_edges();
    send_request(make_request(KIND_REWIND, 0, '0, 0, 32'd8));
    send_request(make_request(KIND_REWIND, 0, '0, 0, 32'd0));
    send_request(make_request(KIND_REWIND, 0, '0, 0, 32'd1));
    send_request(make_request(KIND_REWIND, 1, '0, 0, 32'd0));
    send_request(make_request(KIND_REWIND, 2, '0, 0, 32'hFFFF_FFFF));
    send_request(make_request(KIND_MARKER, 2, '0, 0, '0));
  endtask

  // The unused operation code must answer all zero and leave state alone.
  task automatic test_unused_kind();
    send_request(make_request(KIND_UNUSED, THREADS - 1, 32'hFFFF_FFFF, 15, 32'hFFFF_FFFF));
  endtask

  // Largest base with a large region: addresses of the upper threads pass 32 bits.
  task automatic test_wide_addresses();
    settle_block();
    write_register(CFG_POOL_BASE, 32'hFFFF_FFFF);
    write_register(CFG_REGION_SIZE, 32'h1000_0000);
    send_request(make_request(KIND_MARKER, 7, '0, 0, '0));
    send_request(make_request(KIND_ALLOC, 7, 32'h1000_0000, 15, '0));
    send_request(make_request(KIND_ALLOC, 7, 32'h1000_0000, 0, '0));
    send_request(make_request(KIND_REWIND, 7, '0, 0, 32'hFFFF_FFFF));
  endtask

  // A region made smaller than a thread's fill, then an empty region.
  task automatic test_shrunk_region();
    settle_block();
    write_register(CFG_REGION_SIZE, 32'd16);
    send_request(make_request(KIND_ALLOC, 7, 32'd0, 0, '0));
    send_request(make_request(KIND_MARKER, 7, '0, 0, '0));
    settle_block();
    write_register(CFG_POOL_BASE, 32'd0);
    write_register(CFG_REGION_SIZE, 32'd0);
    send_request(make_request(KIND_ALLOC, 3, 32'd0, 0, '0));
  endtask

  // Random traffic over a series of register settings, extremes first.
  task automatic test_random_traffic();
    logic [ADDR_W-1:0] base_value;
    logic [ADDR_W-1:0] region_value;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      case (phase)
        0: begin
          base_value = 32'd0;
          region_value = 32'd4096;
        end
        1: begin
          base_value = 32'hFFFF_FFFF;
          region_value = 32'h1000_0000;
        end
        2: begin
          base_value = $urandom();
          region_value = 32'd0;
        end
        3: begin
          base_value = 32'd0;
          region_value = 32'd1;
        end
        default: begin
          base_value = $urandom();
          if ($urandom_range(0, 3) == 0) region_value = $urandom_range(32'h1_0000, 32'h1000_0000);
          else region_value = $urandom_range(2, 8192);
        end
      endcase
      write_register(CFG_POOL_BASE, base_value);
      write_register(CFG_REGION_SIZE, region_value);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_request(random_request());
    end
  endtask

  // Reset, then every test in turn, then the verdict.
  initial begin : test_sequence
    mismatch_count = 0;
    idle_max = 7;
    shadow_pool_base = '0;
    shadow_region_size = REGION_SIZE_RST;
    for (int t = 0; t < THREADS; t++) shadow_fill[t] = '0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_POOL_BASE;
    cfg_wdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.kind <= KIND_ALLOC;
    req_bus.thread_index <= '0;
    req_bus.request_size <= '0;
    req_bus.align_shift <= '0;
    req_bus.target_addr <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_markers();
    test_allocate_edges();
    test_rewind_edges();
    test_unused_kind();
    test_wide_addresses();
    test_shrunk_region();
    test_random_traffic();
    settle_block();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
